// ===== sv/scs_pkg.sv =====
// Shared constants and types for the sine/cosine series unit.
// No dependencies; every other file of the unit imports this package.
package scs_pkg;

    // Internal fixed-point format is signed Q7.56 held in 64 bits.
    localparam int unsigned FRAC_BITS = 56;
    localparam logic [63:0] PI_Q56     = 64'h0324_3F6A_8885_A309;
    localparam logic [63:0] TWO_PI_Q56 = 64'h0648_7ED5_110B_4612;
    localparam logic [63:0] ONE_Q56    = 64'h0100_0000_0000_0000;

    // Default number of series terms, and the width that holds any term divisor.
    localparam int unsigned SERIES_STEPS_DEF = 15;
    localparam int unsigned D_W = 11;

    // The turn count never exceeds 20, so five restoring steps find the remainder.
    localparam int unsigned REDUCE_STEPS = 5;

    // Depth of the queue between the front and the back.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);

    // Reduced angle and its square, handed from the front to the back.
    typedef struct packed {
        logic        op;
        logic        xneg;
        logic [63:0] xmag;
        logic [63:0] x2;
    } scs_item_t;

    // Running state of one item inside the series pipeline.
    typedef struct packed {
        logic        op;
        logic        tneg;
        logic [63:0] tmag;
        logic [63:0] x2;
        logic [63:0] sum;
    } scs_acc_t;

endpackage

// ===== sv/scs_front.sv =====
// Front part: accepts angles, reduces them into [-pi, pi] and squares them.
// Depends on scs_pkg.
module scs_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic signed [31:0] s_angle,
    output logic              out_valid,
    output scs_pkg::scs_item_t out_item,
    input  logic              out_full
);
    import scs_pkg::*;

    logic adv;

    logic        in_vld_reg;
    logic        in_op_reg;
    logic        in_neg_reg;
    logic [63:0] in_wide_reg;
    logic [31:0] mag_next;

    logic        red_vld_reg [REDUCE_STEPS];
    logic        red_op_reg  [REDUCE_STEPS];
    logic        red_neg_reg [REDUCE_STEPS];
    logic [63:0] red_rem_reg [REDUCE_STEPS];

    logic        fold_vld_reg;
    logic        fold_op_reg;
    logic        fold_neg_reg;
    logic [63:0] fold_mag_reg;
    logic [63:0] last_rem;

    logic        sq_vld_reg;
    logic        sq_op_reg;
    logic        sq_neg_reg;
    logic [63:0] sq_mag_reg;
    logic [63:0] sq_p00_reg;
    logic [63:0] sq_p01_reg;
    logic [63:0] sq_p11_reg;

    logic         pr_vld_reg;
    logic         pr_op_reg;
    logic         pr_neg_reg;
    logic [63:0]  pr_mag_reg;
    logic [127:0] pr_prod_reg;

    logic      out_vld_reg;
    scs_item_t out_item_reg;

    // The whole front moves together unless its finished item cannot enter the queue.
    assign adv       = !out_vld_reg || !out_full;
    assign s_ready   = adv;
    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

    // Input capture: magnitude of the angle, widened from Q8.24 to Q7.56.
    assign mag_next = s_angle[31] ? (32'd0 - s_angle) : s_angle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_op_reg   <= s_op;
            in_neg_reg  <= s_angle[31];
            in_wide_reg <= {mag_next, 32'd0};
        end
    end

    // Restoring reduction: one multiple of two pi is tried in each stage.
    for (genvar g = 0; g < REDUCE_STEPS; g++) begin : g_red
        localparam logic [63:0] SUB = TWO_PI_Q56 << (REDUCE_STEPS - 1 - g);
        logic        src_vld;
        logic        src_op;
        logic        src_neg;
        logic [63:0] src_rem;

        if (g == 0) begin : g_first
            assign src_vld = in_vld_reg;
            assign src_op  = in_op_reg;
            assign src_neg = in_neg_reg;
            assign src_rem = in_wide_reg;
        end else begin : g_rest
            assign src_vld = red_vld_reg[g-1];
            assign src_op  = red_op_reg[g-1];
            assign src_neg = red_neg_reg[g-1];
            assign src_rem = red_rem_reg[g-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                red_vld_reg[g] <= 1'b0;
            end else if (adv) begin
                red_vld_reg[g] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                red_op_reg[g]  <= src_op;
                red_neg_reg[g] <= src_neg;
                red_rem_reg[g] <= (src_rem >= SUB) ? (src_rem - SUB) : src_rem;
            end
        end
    end

    // Fold: a remainder beyond pi is replaced by its distance to two pi, sign flipped.
    assign last_rem = red_rem_reg[REDUCE_STEPS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_vld_reg <= 1'b0;
        end else if (adv) begin
            fold_vld_reg <= red_vld_reg[REDUCE_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fold_op_reg <= red_op_reg[REDUCE_STEPS-1];
            if (last_rem > PI_Q56) begin
                fold_mag_reg <= TWO_PI_Q56 - last_rem;
                fold_neg_reg <= !red_neg_reg[REDUCE_STEPS-1];
            end else begin
                fold_mag_reg <= last_rem;
                fold_neg_reg <= red_neg_reg[REDUCE_STEPS-1];
            end
        end
    end

    // Square, first half: 32 by 32 partial products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
        end else if (adv) begin
            sq_vld_reg <= fold_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_op_reg  <= fold_op_reg;
            sq_neg_reg <= fold_neg_reg;
            sq_mag_reg <= fold_mag_reg;
            sq_p00_reg <= fold_mag_reg[31:0] * fold_mag_reg[31:0];
            sq_p01_reg <= fold_mag_reg[31:0] * fold_mag_reg[63:32];
            sq_p11_reg <= fold_mag_reg[63:32] * fold_mag_reg[63:32];
        end
    end

    // Square, second half: the partial products are summed to the full product.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_vld_reg <= 1'b0;
        end else if (adv) begin
            pr_vld_reg <= sq_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr_op_reg   <= sq_op_reg;
            pr_neg_reg  <= sq_neg_reg;
            pr_mag_reg  <= sq_mag_reg;
            pr_prod_reg <= {64'd0, sq_p00_reg} + {31'd0, sq_p01_reg, 33'd0}
                         + {sq_p11_reg, 64'd0};
        end
    end

    // Rounding back to Q7.56 gives the square of the reduced angle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= pr_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_item_reg.op   <= pr_op_reg;
            out_item_reg.xneg <= pr_neg_reg;
            out_item_reg.xmag <= pr_mag_reg;
            out_item_reg.x2   <= pr_prod_reg[119:56] + {63'd0, pr_prod_reg[55]};
        end
    end

endmodule

// ===== sv/scs_fifo.sv =====
// Short queue that decouples the front part from the series pipeline.
// Depends on scs_pkg.
module scs_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  scs_pkg::scs_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output scs_pkg::scs_item_t pop_item
);
    import scs_pkg::*;

    scs_item_t          buf_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0] wr_ptr_reg;
    logic [FIFO_PW-1:0] rd_ptr_reg;
    logic [FIFO_PW:0]   count_reg;

    assign full     = (count_reg == (FIFO_PW + 1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = buf_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage of the queued items.
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/scs_step.sv =====
// One Taylor step: term times x squared, then rounded division by the term constant.
// Depends on scs_pkg.
module scs_step #(
    parameter int unsigned STEP = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              vld_i,
    input  scs_pkg::scs_acc_t acc_i,
    output logic              vld_o,
    output scs_pkg::scs_acc_t acc_o
);
    import scs_pkg::*;

    // Divisors of this step and their reciprocals scaled by two to the 64th.
    localparam logic [D_W-1:0] D_SIN  = D_W'((2 * STEP) * (2 * STEP + 1));
    localparam logic [D_W-1:0] D_COS  = D_W'((2 * STEP - 1) * (2 * STEP));
    localparam logic [64:0]    TWO64  = 65'd1 << 64;
    localparam logic [63:0]    R_SIN  = 64'(TWO64 / D_SIN);
    localparam logic [63:0]    R_COS  = 64'(TWO64 / D_COS);
    localparam logic [D_W-1:0] DH_SIN = D_SIN >> 1;
    localparam logic [D_W-1:0] DH_COS = D_COS >> 1;

    logic        s1_vld_reg;
    scs_acc_t    s1_acc_reg;
    logic [63:0] s1_pp_reg [4];

    logic         s2_vld_reg;
    scs_acc_t     s2_acc_reg;
    logic [127:0] s2_prod_reg;

    logic        s3_vld_reg;
    scs_acc_t    s3_acc_reg;
    logic [63:0] s3_n_reg;
    logic [D_W-1:0] dh_sel;

    logic        s4_vld_reg;
    scs_acc_t    s4_acc_reg;
    logic [63:0] s4_n_reg;
    logic [63:0] s4_pp_reg [4];
    logic [63:0] r_sel;

    logic         s5_vld_reg;
    scs_acc_t     s5_acc_reg;
    logic [63:0]  s5_n_reg;
    logic [63:0]  s5_qe_reg;
    logic [127:0] qprod_next;

    logic        s6_vld_reg;
    scs_acc_t    s6_acc_reg;
    logic [63:0] s6_qe_reg;
    logic        s6_corr_reg;
    logic [D_W-1:0] d_sel;
    logic [15:0] qd_next;
    logic [15:0] rem_next;

    logic        s7_vld_reg;
    scs_acc_t    s7_acc_reg;
    logic [63:0] qm_next;
    logic        neg_next;

    assign vld_o = s7_vld_reg;
    assign acc_o = s7_acc_reg;

    // Valid bits of all stages move with the shared enable.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= vld_i;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
        end
    end

    // Combinational selections by function.
    assign dh_sel = s2_acc_reg.op ? DH_COS : DH_SIN;
    assign r_sel  = s3_acc_reg.op ? R_COS : R_SIN;
    assign d_sel  = s5_acc_reg.op ? D_COS : D_SIN;

    assign qprod_next = {64'd0, s4_pp_reg[0]} + {32'd0, s4_pp_reg[1], 32'd0}
                      + {32'd0, s4_pp_reg[2], 32'd0} + {s4_pp_reg[3], 64'd0};

    // The remainder of the quotient estimate is below twice the divisor, so 16 bits hold it.
    assign qd_next  = s5_qe_reg[15:0] * {{(16 - D_W){1'b0}}, d_sel};
    assign rem_next = s5_n_reg[15:0] - qd_next;

    assign qm_next  = s6_qe_reg + {63'd0, s6_corr_reg};
    assign neg_next = !s6_acc_reg.tneg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // Partial products of the term magnitude and x squared.
            s1_acc_reg   <= acc_i;
            s1_pp_reg[0] <= acc_i.tmag[31:0]  * acc_i.x2[31:0];
            s1_pp_reg[1] <= acc_i.tmag[31:0]  * acc_i.x2[63:32];
            s1_pp_reg[2] <= acc_i.tmag[63:32] * acc_i.x2[31:0];
            s1_pp_reg[3] <= acc_i.tmag[63:32] * acc_i.x2[63:32];

            // Full product.
            s2_acc_reg  <= s1_acc_reg;
            s2_prod_reg <= {64'd0, s1_pp_reg[0]} + {32'd0, s1_pp_reg[1], 32'd0}
                         + {32'd0, s1_pp_reg[2], 32'd0} + {s1_pp_reg[3], 64'd0};

            // Rounded product plus half the divisor gives the dividend.
            s3_acc_reg <= s2_acc_reg;
            s3_n_reg   <= s2_prod_reg[119:56] + {63'd0, s2_prod_reg[55]}
                        + {{(64 - D_W){1'b0}}, dh_sel};

            // Partial products of the dividend and the reciprocal.
            s4_acc_reg   <= s3_acc_reg;
            s4_n_reg     <= s3_n_reg;
            s4_pp_reg[0] <= s3_n_reg[31:0]  * r_sel[31:0];
            s4_pp_reg[1] <= s3_n_reg[31:0]  * r_sel[63:32];
            s4_pp_reg[2] <= s3_n_reg[63:32] * r_sel[31:0];
            s4_pp_reg[3] <= s3_n_reg[63:32] * r_sel[63:32];

            // Quotient estimate, never above the true quotient and at most one below.
            s5_acc_reg <= s4_acc_reg;
            s5_n_reg   <= s4_n_reg;
            s5_qe_reg  <= qprod_next[127:64];

            // Correction when the remainder still reaches the divisor.
            s6_acc_reg  <= s5_acc_reg;
            s6_qe_reg   <= s5_qe_reg;
            s6_corr_reg <= (rem_next >= {{(16 - D_W){1'b0}}, d_sel});

            // New term has the opposite sign; it is added to the running sum.
            s7_acc_reg.op   <= s6_acc_reg.op;
            s7_acc_reg.x2   <= s6_acc_reg.x2;
            s7_acc_reg.tneg <= neg_next;
            s7_acc_reg.tmag <= qm_next;
            s7_acc_reg.sum  <= neg_next ? (s6_acc_reg.sum - qm_next)
                                        : (s6_acc_reg.sum + qm_next);
        end
    end

endmodule

// ===== sv/scs_back.sv =====
// Back part: Taylor series pipeline and conversion of the sum to Q2.30.
// Depends on scs_pkg and scs_step.
module scs_back #(
    parameter int unsigned SERIES_STEPS = scs_pkg::SERIES_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  scs_pkg::scs_item_t q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value
);
    import scs_pkg::*;

    logic en;

    logic     ch_vld [SERIES_STEPS];
    scs_acc_t ch_acc [SERIES_STEPS];

    logic     ini_vld_reg;
    scs_acc_t ini_acc_reg;
    logic     tneg_next;
    logic [63:0] tmag_next;

    logic        cv_vld_reg;
    logic        cv_neg_reg;
    logic [38:0] cv_rm_reg;
    logic [63:0] fin_sum;
    logic [63:0] sm_next;
    logic [64:0] rnd_next;

    logic        m_valid_reg;
    logic [31:0] m_value_reg;

    // The series pipeline advances whenever the output register is free or being emptied.
    assign en      = !m_valid_reg || m_ready;
    assign q_pop   = en && !q_empty;
    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    // First term: x for sine, one for cosine.
    assign tneg_next = q_item.op ? 1'b0 : q_item.xneg;
    assign tmag_next = q_item.op ? ONE_Q56 : q_item.xmag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ini_vld_reg <= 1'b0;
        end else if (en) begin
            ini_vld_reg <= !q_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ini_acc_reg.op   <= q_item.op;
            ini_acc_reg.x2   <= q_item.x2;
            ini_acc_reg.tneg <= tneg_next;
            ini_acc_reg.tmag <= tmag_next;
            ini_acc_reg.sum  <= tneg_next ? (64'd0 - tmag_next) : tmag_next;
        end
    end

    assign ch_vld[0] = ini_vld_reg;
    assign ch_acc[0] = ini_acc_reg;

    // One pipelined unit per further term.
    for (genvar i = 1; i < SERIES_STEPS; i++) begin : g_step
        scs_step #(
            .STEP (i)
        ) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vld_i   (ch_vld[i-1]),
            .acc_i   (ch_acc[i-1]),
            .vld_o   (ch_vld[i]),
            .acc_o   (ch_acc[i])
        );
    end

    // Magnitude of the sum rounded to Q2.30.
    assign fin_sum  = ch_acc[SERIES_STEPS-1].sum;
    assign sm_next  = fin_sum[63] ? (64'd0 - fin_sum) : fin_sum;
    assign rnd_next = {1'b0, sm_next} + (65'd1 << (FRAC_BITS - 31));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_vld_reg <= 1'b0;
        end else if (en) begin
            cv_vld_reg <= ch_vld[SERIES_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cv_neg_reg <= fin_sum[63];
            cv_rm_reg  <= rnd_next[64:26];
        end
    end

    // Output register with saturation to the signed 32-bit range.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cv_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (cv_neg_reg) begin
                if (cv_rm_reg > 39'h0080000000) begin
                    m_value_reg <= 32'h8000_0000;
                end else begin
                    m_value_reg <= 32'd0 - cv_rm_reg[31:0];
                end
            end else begin
                if (cv_rm_reg > 39'h007FFFFFFF) begin
                    m_value_reg <= 32'h7FFF_FFFF;
                end else begin
                    m_value_reg <= cv_rm_reg[31:0];
                end
            end
        end
    end

endmodule

// ===== sv/sine_cosine_series_unit.sv =====
// Top level of the sine/cosine series unit: front, queue and series pipeline.
// Depends on scs_pkg, scs_front, scs_fifo and scs_back.
//
//   Channel   Ports                          Payload
//   input     s_valid, s_ready, s_op, s_angle op (0 sine, 1 cosine), angle Q8.24
//   result    m_valid, m_ready, m_value       value Q2.30
//
// One transaction is accepted per cycle and one result leaves per cycle when
// m_ready stays high. Without stalls the path runs through ten front stages,
// the queue, the first-term stage, seven stages per further term set by the
// two split 64-bit multiplications of each term, and the conversion and
// output stages.
// Reset is synchronous and active low; it clears only the valid bits and queue.
// A stall on m_ready holds the series pipeline; the front keeps accepting until
// the four-entry queue and the last front stage are full.
module sine_cosine_series_unit #(
    parameter int unsigned SERIES_STEPS = scs_pkg::SERIES_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [31:0] s_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value
);
    import scs_pkg::*;

    logic      fr_valid;
    scs_item_t fr_item;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    scs_item_t q_item;

    // Range reduction and squaring.
    scs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_angle   (s_angle),
        .out_valid (fr_valid),
        .out_item  (fr_item),
        .out_full  (q_full)
    );

    // Decoupling queue.
    scs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fr_valid && !q_full),
        .push_item (fr_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (q_item)
    );

    // Series evaluation and output.
    scs_back #(
        .SERIES_STEPS (SERIES_STEPS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value)
    );

endmodule
